[design/rri2d_pkg.sv]
// rri2d_pkg: shared types and constants of the 2D ray / rectangle intersect unit.
// Payload structs for the input and result channels. No dependencies.

package rri2d_pkg;

  // Coordinate word width, signed Q16.16.
  localparam int unsigned CoordW = 32;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] rect_min_x;
    logic signed [CoordW-1:0] rect_min_y;
    logic signed [CoordW-1:0] rect_max_x;
    logic signed [CoordW-1:0] rect_max_y;
  } ray_in_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
    logic        [CoordW-1:0] distance;
  } ray_out_t;

endpackage

[design/ray_rect_intersect_2d_unit.sv]
// ray_rect_intersect_2d_unit: pipelined nearest hit of a 2D ray on an
// axis-aligned rectangle (slab method, fixed point). Depends on rri2d_pkg.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------
//   in      | in  | in_valid_i / in_stall_o | in_data_i  (ray + rect)
//   out     | out | out_valid_o / out_stall_i | out_data_o (hit, point, dist)
//
// Throughput: one transfer per cycle on each side while out_stall_i stays low.
// Depth: most of the pipe is the CoordW+1 divide steps and the CoordW+1
//   square-root steps.
// Reset: clears stage valid bits and the output/skid valids only; no sweep.
// Stalls: in_stall_o comes from a register (skid entry full); while it is high
//   the whole pipe holds, and no transfer is lost or repeated.

module ray_rect_intersect_2d_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rri2d_pkg::ray_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rri2d_pkg::ray_out_t out_data_o
);
  import rri2d_pkg::*;

  localparam int unsigned CW       = CoordW;
  localparam int unsigned NumLanes = 4;            // planes: x max, x min, y max, y min
  localparam int unsigned HalfW    = (CW + 1) / 2; // low split of multiplier operand
  localparam int unsigned HiW      = CW + 1 - HalfW;
  localparam int unsigned PLW      = CW + HalfW;
  localparam int unsigned PHW      = CW + HiW;
  localparam int unsigned DLW      = CW + 1 + HalfW;
  localparam int unsigned DHW      = CW + 1 + HiW;
  localparam int unsigned NumW     = 2 * CW;
  localparam int unsigned DdW      = 2 * CW + 1;
  localparam int unsigned D2W      = 2 * CW + 2;

  // Stage map (stage 0 holds the captured input).
  localparam int unsigned StSetup   = 1;
  localparam int unsigned StMag     = 2;
  localparam int unsigned StMul     = 3;
  localparam int unsigned StSum     = 4;
  localparam int unsigned StSat     = 5;
  localparam int unsigned StDiv0    = 6;
  localparam int unsigned StPos     = StDiv0 + CW + 1;
  localparam int unsigned StD2      = StPos + 1;
  localparam int unsigned StPair    = StD2 + 1;
  localparam int unsigned StBest    = StPair + 1;
  localparam int unsigned StSqrt0   = StBest + 1;
  localparam int unsigned NumStages = StSqrt0 + CW + 1;

  typedef struct packed {
    logic                 ok;     // plane is a candidate
    logic                 bneg;   // direction on the other axis is negative
    logic signed [CW:0]   diff;   // bound - origin on the plane's axis
    logic        [CW:0]   dmag;
    logic        [CW-1:0] amag;
    logic        [CW-1:0] bmag;
    logic signed [CW-1:0] bound;
    logic signed [CW-1:0] orgb;
    logic signed [CW-1:0] lob;
    logic signed [CW-1:0] hib;
    logic [PLW-1:0]       pp_lo;
    logic [PHW-1:0]       pp_hi;
    logic [DLW-1:0]       dd_lo;
    logic [DHW-1:0]       dd_hi;
    logic [NumW-1:0]      num;    // |dir_b| * |diff|
    logic [DdW-1:0]       dd;     // diff^2
    logic                 sat;    // quotient too large to land inside
    logic [CW:0]          rem;
    logic [CW:0]          quo;
    logic                 in_rect;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic [DLW-1:0]       mm_lo;
    logic [DHW-1:0]       mm_hi;
    logic [D2W-1:0]       d2;
  } lane_t;

  typedef struct packed {
    logic                 found;
    logic [D2W-1:0]       d2;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } sel_t;

  typedef struct packed {
    ray_in_t                   item;
    lane_t [NumLanes-1:0]      ln;
    sel_t  [1:0]               pair;
    sel_t                      best;
    logic  [CW+2:0]            srem;
    logic  [CW:0]              root;
  } stage_t;

  // Later candidate wins on a tie.
  function automatic sel_t sel_pick(input sel_t e, input sel_t l);
    sel_t r;
    r = (l.found && (!e.found || l.d2 <= e.d2)) ? l : e;
    return r;
  endfunction

  function automatic sel_t lane_sel(input lane_t l);
    sel_t r;
    r.found = l.in_rect;
    r.d2    = l.d2;
    r.px    = l.px;
    r.py    = l.py;
    return r;
  endfunction

  function automatic stage_t step_f(input int unsigned k, input stage_t s);
    stage_t               r;
    logic signed [CW-1:0] org [2];
    logic signed [CW-1:0] dir [2];
    logic signed [CW-1:0] lo  [2];
    logic signed [CW-1:0] hi  [2];
    logic        [CW-1:0] ua;
    logic        [CW-1:0] ub;
    logic        [CW:0]   ud;
    logic        [CW:0]   rr;
    logic signed [CW+2:0] qs;
    logic signed [CW+2:0] pb;
    logic        [CW+3:0] sr;
    logic        [CW+3:0] st;
    logic        [CW+3:0] sd;
    logic                 a;
    logic                 b;
    int unsigned          j;
    r      = s;
    org[0] = s.item.origin_x;   org[1] = s.item.origin_y;
    dir[0] = s.item.dir_x;      dir[1] = s.item.dir_y;
    lo[0]  = s.item.rect_min_x; lo[1]  = s.item.rect_min_y;
    hi[0]  = s.item.rect_max_x; hi[1]  = s.item.rect_max_y;
    for (int i = 0; i < NumLanes; i++) begin
      a = i[1];
      b = !a;
      if (k == StSetup) begin
        r.ln[i].bound = i[0] ? lo[a] : hi[a];
        r.ln[i].orgb  = org[b];
        r.ln[i].lob   = lo[b];
        r.ln[i].hib   = hi[b];
        r.ln[i].diff  = {r.ln[i].bound[CW-1], r.ln[i].bound} - {org[a][CW-1], org[a]};
        ua = dir[a];
        ub = dir[b];
        r.ln[i].amag  = ua[CW-1] ? -ua : ua;
        r.ln[i].bmag  = ub[CW-1] ? -ub : ub;
        r.ln[i].bneg  = ub[CW-1];
        r.ln[i].ok    = (dir[a] != '0) && (lo[a] <= hi[a]) &&
                        ((r.ln[i].diff == '0) || (r.ln[i].diff[CW] == ua[CW-1]));
      end else if (k == StMag) begin
        ud = s.ln[i].diff;
        r.ln[i].dmag = ud[CW] ? -ud : ud;
      end else if (k == StMul) begin
        r.ln[i].pp_lo = PLW'(s.ln[i].bmag) * PLW'(s.ln[i].dmag[HalfW-1:0]);
        r.ln[i].pp_hi = PHW'(s.ln[i].bmag) * PHW'(s.ln[i].dmag[CW:HalfW]);
        r.ln[i].dd_lo = DLW'(s.ln[i].dmag) * DLW'(s.ln[i].dmag[HalfW-1:0]);
        r.ln[i].dd_hi = DHW'(s.ln[i].dmag) * DHW'(s.ln[i].dmag[CW:HalfW]);
      end else if (k == StSum) begin
        r.ln[i].num = NumW'(s.ln[i].pp_lo) + (NumW'(s.ln[i].pp_hi) << HalfW);
        r.ln[i].dd  = DdW'(s.ln[i].dd_lo) + (DdW'(s.ln[i].dd_hi) << HalfW);
      end else if (k == StSat) begin
        r.ln[i].rem = (CW+1)'(s.ln[i].num[NumW-1:CW+1]);
        r.ln[i].sat = r.ln[i].rem >= {1'b0, s.ln[i].amag};
        r.ln[i].quo = '0;
      end else if (k >= StDiv0 && k < StPos) begin
        // restoring divide, one quotient bit per stage
        j  = k - StDiv0;
        rr = {s.ln[i].rem[CW-1:0], s.ln[i].num[CW-j]};
        if (rr >= {1'b0, s.ln[i].amag}) begin
          r.ln[i].rem = rr - {1'b0, s.ln[i].amag};
          r.ln[i].quo = {s.ln[i].quo[CW-1:0], 1'b1};
        end else begin
          r.ln[i].rem = rr;
          r.ln[i].quo = {s.ln[i].quo[CW-1:0], 1'b0};
        end
      end else if (k == StPos) begin
        qs = $signed({2'b00, s.ln[i].quo});
        if (s.ln[i].bneg) begin
          qs = -qs;
        end
        pb = $signed({{3{s.ln[i].orgb[CW-1]}}, s.ln[i].orgb}) + qs;
        r.ln[i].in_rect = s.ln[i].ok && !s.ln[i].sat &&
                          (pb >= $signed({{3{s.ln[i].lob[CW-1]}}, s.ln[i].lob})) &&
                          (pb <= $signed({{3{s.ln[i].hib[CW-1]}}, s.ln[i].hib}));
        if (!a) begin
          r.ln[i].px = s.ln[i].bound;
          r.ln[i].py = pb[CW-1:0];
        end else begin
          r.ln[i].px = pb[CW-1:0];
          r.ln[i].py = s.ln[i].bound;
        end
        r.ln[i].mm_lo = DLW'(s.ln[i].quo) * DLW'(s.ln[i].quo[HalfW-1:0]);
        r.ln[i].mm_hi = DHW'(s.ln[i].quo) * DHW'(s.ln[i].quo[CW:HalfW]);
      end else if (k == StD2) begin
        r.ln[i].d2 = D2W'(s.ln[i].dd) + D2W'(s.ln[i].mm_lo) +
                     (D2W'(s.ln[i].mm_hi) << HalfW);
      end
    end
    if (k == StPair) begin
      r.pair[0] = sel_pick(lane_sel(s.ln[0]), lane_sel(s.ln[1]));
      r.pair[1] = sel_pick(lane_sel(s.ln[2]), lane_sel(s.ln[3]));
    end else if (k == StBest) begin
      r.best = sel_pick(s.pair[0], s.pair[1]);
      r.srem = '0;
      r.root = '0;
    end else if (k >= StSqrt0) begin
      // digit-by-digit square root, two radicand bits per stage
      j  = k - StSqrt0;
      sr = {s.srem[CW+1:0], s.best.d2[D2W-1-2*j -: 2]};
      st = {1'b0, s.root, 2'b01};
      if (sr >= st) begin
        sd     = sr - st;
        r.srem = sd[CW+2:0];
        r.root = {s.root[CW-1:0], 1'b1};
      end else begin
        r.srem = sr[CW+2:0];
        r.root = {s.root[CW-1:0], 1'b0};
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- pipe
  logic                 en;       // whole pipe advances
  logic [NumStages-1:0] v_q;
  stage_t               stage_q [NumStages];
  stage_t               stage_d [NumStages];
  logic                 out_valid_q;
  logic                 skid_valid_q;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NumStages-2:0], in_valid_i};
    end
  end

  always_comb begin
    stage_d[0]      = '0;
    stage_d[0].item = in_data_i;
  end

  for (genvar g = 1; g < NumStages; g++) begin : g_stage
    assign stage_d[g] = step_f(g, stage_q[g-1]);
  end

  for (genvar g = 0; g < NumStages; g++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en) begin
        stage_q[g] <= stage_d[g];
      end
    end
  end

  // ------------------------------------------------------- result format
  ray_out_t tail;
  always_comb begin
    if (stage_q[NumStages-1].best.found) begin
      tail.hit      = 1'b1;
      tail.hit_x    = stage_q[NumStages-1].best.px;
      tail.hit_y    = stage_q[NumStages-1].best.py;
      tail.distance = stage_q[NumStages-1].root[CW] ? '1 :
                      stage_q[NumStages-1].root[CW-1:0];
    end else begin
      tail.hit      = 1'b0;
      tail.hit_x    = '0;
      tail.hit_y    = '0;
      tail.distance = '1;
    end
  end

  // ------------------------------------------------ output reg + skid entry
  ray_out_t out_q;
  ray_out_t skid_q;
  logic     take;

  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_q <= v_q[NumStages-1];
    end else if (v_q[NumStages-1]) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || take) begin
      out_q <= tail;
    end else begin
      skid_q <= tail;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------- assertions
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_skid_catch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !skid_valid_q && v_q[NumStages-1]) |=> skid_valid_q)
    else $error("stalled pipe tail not caught in skid entry");

  a_no_hit_fmt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |->
      (out_data_o.hit_x == '0 && out_data_o.hit_y == '0 && out_data_o.distance == '1))
    else $error("miss result not in canonical form");

  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted transfer did not enter the pipe");

endmodule

[tb/sv/ray_rect_intersect_2d_unit_test.sv]
// ray_rect_intersect_2d_unit_test: self-checking bench for the 2D ray / rectangle
// intersect unit. Holds a slab-method predictor and a result scoreboard.
// Depends on rri2d_pkg and ray_rect_intersect_2d_unit.

`timescale 1ns / 100ps

class ray_hit_board;
  rri2d_pkg::ray_out_t pending_hits[$];
  int unsigned errors = 0;

  // Floor of n / d (d != 0), clamped at 2^62.
  static function logic [63:0] div_clamp(logic [127:0] n, logic [63:0] d);
    logic [127:0] q;
    q = n / {64'd0, d};
    if (q >= (128'd1 << 62)) return 64'd1 << 62;
    return q[63:0];
  endfunction

  static function logic [63:0] isqrt(logic [127:0] n);
    logic [63:0]  res;
    logic [63:0]  c;
    res = 0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) res = c;
    end
    return res;
  endfunction

  static function logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Planes in order x max, x min, y max, y min; later plane wins ties.
  static function rri2d_pkg::ray_out_t predict_hit(rri2d_pkg::ray_in_t r);
    rri2d_pkg::ray_out_t res;
    logic signed [63:0] org[2], dir[2], lo[2], hi[2], pt[2];
    logic signed [63:0] bound, diff, off, pb;
    logic [63:0]  m, s;
    logic [127:0] d2, best;
    bit found;
    int a, b;
    org[0] = r.origin_x;   org[1] = r.origin_y;
    dir[0] = r.dir_x;      dir[1] = r.dir_y;
    lo[0] = r.rect_min_x;  lo[1] = r.rect_min_y;
    hi[0] = r.rect_max_x;  hi[1] = r.rect_max_y;
    pt[0] = 0; pt[1] = 0; best = 0; found = 0;
    for (int p = 0; p < 4; p++) begin
      a = p >> 1; b = a ^ 1;
      bound = p[0] ? lo[a] : hi[a];
      if (dir[a] == 0) continue;
      diff = bound - org[a];
      if (diff != 0 && ((diff < 0) != (dir[a] < 0))) continue;
      if (lo[a] > hi[a]) continue;
      m = div_clamp({64'd0, abs64(dir[b])} * {64'd0, abs64(diff)}, abs64(dir[a]));
      off = dir[b] < 0 ? -$signed(m) : $signed(m);
      pb = org[b] + off;
      if (pb < lo[b] || pb > hi[b]) continue;
      d2 = {64'd0, abs64(diff)} * {64'd0, abs64(diff)} + {64'd0, m} * {64'd0, m};
      if (!found || d2 <= best) begin
        found = 1; best = d2; pt[a] = bound; pt[b] = pb;
      end
    end
    if (found) begin
      s = isqrt(best);
      res.hit = 1'b1;
      res.hit_x = pt[0][31:0];
      res.hit_y = pt[1][31:0];
      res.distance = (s > 64'hffff_ffff) ? '1 : s[31:0];
    end else begin
      res.hit = 1'b0; res.hit_x = '0; res.hit_y = '0; res.distance = '1;
    end
    return res;
  endfunction

  function void note_ray(rri2d_pkg::ray_in_t r);
    pending_hits.push_back(predict_hit(r));
  endfunction

  function void check_hit(rri2d_pkg::ray_out_t got);
    rri2d_pkg::ray_out_t exp;
    if (pending_hits.size() == 0) begin
      $error("unexpected result transfer");
      errors++;
      return;
    end
    exp = pending_hits.pop_front();
    if (got.hit !== exp.hit) begin
      $error("hit exp %0d got %0d", exp.hit, got.hit); errors++;
    end
    if (got.hit_x !== exp.hit_x) begin
      $error("hit_x exp %h got %h", exp.hit_x, got.hit_x); errors++;
    end
    if (got.hit_y !== exp.hit_y) begin
      $error("hit_y exp %h got %h", exp.hit_y, got.hit_y); errors++;
    end
    if (got.distance !== exp.distance) begin
      $error("distance exp %h got %h", exp.distance, got.distance); errors++;
    end
  endfunction
endclass

module ray_rect_intersect_2d_unit_test;
  import rri2d_pkg::*;

  localparam int unsigned Latency = 2 * CoordW + 12;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned NumRandom = 630;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  ray_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  ray_out_t out_data_o;

  ray_hit_board board = new();
  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 76;
  int unsigned idle_cycles = 0;

  ray_rect_intersect_2d_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: random stalls; check every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_hit(out_data_o);
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'd0;
      default: return $signed($urandom_range(40 << 16)) - $signed(20 << 16);
    endcase
  endfunction

  // Mostly well-formed rays with a proper rectangle (min <= max).
  function automatic ray_in_t rand_ray();
    ray_in_t r;
    logic signed [31:0] a, b;
    r.origin_x = rand_coord(); r.origin_y = rand_coord();
    r.dir_x = rand_coord();    r.dir_y = rand_coord();
    a = rand_coord(); b = rand_coord();
    r.rect_min_x = (a < b) ? a : b; r.rect_max_x = (a < b) ? b : a;
    a = rand_coord(); b = rand_coord();
    r.rect_min_y = (a < b) ? a : b; r.rect_max_y = (a < b) ? b : a;
    if ($urandom_range(9) == 0) r = {$urandom(), $urandom(), $urandom(), $urandom(),
                                     $urandom(), $urandom(), $urandom(), $urandom()};
    else if ($urandom_range(9) == 0) r.dir_x = 0;
    else if ($urandom_range(9) == 0) r.dir_y = 0;
    return r;
  endfunction

  // One input transfer; valid stays high across back-to-back items.
  task automatic send_ray(ray_in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_ray(r);
  endtask

  function automatic ray_in_t mk(int ox, int oy, int dx, int dy,
                                 int x0, int y0, int x1, int y1);
    ray_in_t r;
    r.origin_x = ox; r.origin_y = oy; r.dir_x = dx; r.dir_y = dy;
    r.rect_min_x = x0; r.rect_min_y = y0; r.rect_max_x = x1; r.rect_max_y = y1;
    return r;
  endfunction

  initial begin
    localparam int One = 1 << 16;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: plain hits from each side, zero direction, origin on plane,
    // inverted rectangle, corner tie, extremes and far offsets.
    send_ray(mk(-5*One, 0, One, 0, -One, -One, One, One));
    send_ray(mk(5*One, 0, -One, 0, -One, -One, One, One));
    send_ray(mk(0, -5*One, 0, One, -One, -One, One, One));
    send_ray(mk(0, 5*One, 0, -One, -One, -One, One, One));
    send_ray(mk(0, 0, 0, 0, -One, -One, One, One));
    send_ray(mk(One, 0, One, 0, -One, -One, One, One));
    send_ray(mk(0, 0, One, One, -One, -One, One, One));
    send_ray(mk(-5*One, 0, One, 0, One, -One, -One, One));
    send_ray(mk(-5*One, 0, -One, 0, -One, -One, One, One));
    send_ray(mk(-2*One, -2*One, One, One, -One, -One, One, One));
    send_ray(mk(0, 0, 1, 32'h7fff_ffff, -One, -One, One, One));
    send_ray(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    send_ray(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    send_ray(mk(32'h8000_0000, 0, 1, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    send_ray(mk(0, 0, -1, -1, 32'h8000_0000, 32'h8000_0000, 0, 0));
    send_ray(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    // Random, three idling phases.
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) begin
        send_idle_pct = 76; recv_idle_pct = 22;
      end else if (i == 2 * NumRandom / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      send_ray(rand_ray());
    end
    in_valid_i <= 1'b0;
    while (board.pending_hits.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (board.errors == 0 && board.pending_hits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
